// File: sv/amb_pkg.sv
`default_nettype none
package amb_pkg;

  // Number of CORDIC steps, capped at the length of the arctangent table.
  localparam int TrigIterations = 16;
  localparam int AtanSteps      = 24;
  localparam int CordicSteps    = (TrigIterations < AtanSteps) ? TrigIterations : AtanSteps;
  // Register stages through the sine/cosine unit: reduction, the steps, flip and clamp.
  localparam int CordicLat      = CordicSteps + 2;

  localparam logic signed [33:0] Q28TwoPi  = 34'sd1686629713;
  localparam logic signed [33:0] Q28Pi     = 34'sd843314857;
  localparam logic signed [33:0] Q28HalfPi = 34'sd421657428;
  localparam logic signed [33:0] Q30Gain   = 34'sd652032874;
  localparam logic signed [33:0] Q30One    = 34'sd1073741824;
  localparam logic signed [31:0] Q16One    = 32'sd65536;

  localparam logic signed [33:0] AtanTable [AtanSteps] = '{
    34'sd210828714, 34'sd124459457, 34'sd65760959, 34'sd33381290, 34'sd16755422,
    34'sd8385879, 34'sd4193963, 34'sd2097109, 34'sd1048571, 34'sd524287,
    34'sd262144, 34'sd131072, 34'sd65536, 34'sd32768, 34'sd16384, 34'sd8192,
    34'sd4096, 34'sd2048, 34'sd1024, 34'sd512, 34'sd256, 34'sd128, 34'sd64, 34'sd32
  };

  typedef struct packed {
    logic signed [15:0] angle_x;
    logic signed [15:0] angle_y;
    logic signed [15:0] angle_z;
    logic signed [31:0] scale_x;
    logic signed [31:0] scale_y;
    logic signed [31:0] scale_z;
    logic signed [31:0] shift_x;
    logic signed [31:0] shift_y;
    logic signed [31:0] shift_z;
  } in_beat_t;

  typedef struct packed {
    logic [1:0]         row_index;
    logic signed [31:0] entry_0;
    logic signed [31:0] entry_1;
    logic signed [31:0] entry_2;
    logic signed [31:0] entry_3;
    logic               last_row;
  } out_beat_t;

  // Scale and translation that travel beside the angles.
  typedef struct packed {
    logic signed [31:0] scale_x;
    logic signed [31:0] scale_y;
    logic signed [31:0] scale_z;
    logic signed [31:0] shift_x;
    logic signed [31:0] shift_y;
    logic signed [31:0] shift_z;
  } side_t;

  // Cosines and sines in Q30, clamped to plus or minus one.
  typedef struct packed {
    logic signed [31:0] cx;
    logic signed [31:0] sx;
    logic signed [31:0] cy;
    logic signed [31:0] sy;
    logic signed [31:0] cz;
    logic signed [31:0] sz;
  } trig_t;

  // Scaled matrix entries before saturation, plus the translation column.
  typedef struct packed {
    logic signed [34:0] m00;
    logic signed [34:0] m01;
    logic signed [34:0] m02;
    logic signed [34:0] m10;
    logic signed [34:0] m11;
    logic signed [34:0] m12;
    logic signed [34:0] m20;
    logic signed [34:0] m21;
    logic signed [34:0] m22;
    logic signed [31:0] shift_x;
    logic signed [31:0] shift_y;
    logic signed [31:0] shift_z;
  } mat_t;

  // Product of two Q30 values, rounded back to Q30.
  function automatic logic signed [31:0] mul30(logic signed [31:0] a, logic signed [31:0] b);
    logic signed [63:0] p;
    p = 64'(a) * 64'(b) + (64'sd1 <<< 29);
    return 32'(p >>> 30);
  endfunction

  // Q30 rotation entry times Q16.16 scale, rounded to Q16.16, not yet saturated.
  function automatic logic signed [34:0] scale30(logic signed [32:0] r, logic signed [31:0] s);
    logic signed [64:0] p;
    p = 65'(r) * 65'(s) + (65'sd1 <<< 29);
    return 35'(p >>> 30);
  endfunction

  // Saturate to the signed 32-bit range.
  function automatic logic signed [31:0] sat32(logic signed [34:0] v);
    logic signed [31:0] r;
    if (v > 35'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -35'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// File: sv/amb_cordic.sv
`default_nettype none
module amb_cordic (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_valid,
  input  logic signed [15:0] angle,
  output logic               out_valid,
  output logic signed [31:0] cos_q,
  output logic signed [31:0] sin_q
);
  import amb_pkg::*;

  logic signed [33:0] x_q [CordicSteps+1];
  logic signed [33:0] y_q [CordicSteps+1];
  logic signed [33:0] z_q [CordicSteps+1];
  logic               f_q [CordicSteps+1];
  logic [CordicSteps:0] v_q;

  logic signed [33:0] z_wide, z_wrap, z_red;
  logic               flip;
  logic signed [33:0] x_fin, y_fin;

  // Angle to Q28, one wrap into (-pi, pi], then fold into the right half-plane.
  always_comb begin
    z_wide = 34'(angle) <<< 16;
    if (z_wide > Q28Pi) begin
      z_wrap = z_wide - Q28TwoPi;
    end else if (z_wide <= -Q28Pi) begin
      z_wrap = z_wide + Q28TwoPi;
    end else begin
      z_wrap = z_wide;
    end
    flip = 1'b1;
    if (z_wrap > Q28HalfPi) begin
      z_red = z_wrap - Q28Pi;
    end else if (z_wrap < -Q28HalfPi) begin
      z_red = z_wrap + Q28Pi;
    end else begin
      z_red = z_wrap;
      flip  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_q[0] <= Q30Gain;
      y_q[0] <= '0;
      z_q[0] <= z_red;
      f_q[0] <= flip;
    end
  end

  // One rotation step per stage.
  for (genvar k = 0; k < CordicSteps; k++) begin : g_step
    always_ff @(posedge clk) begin
      if (en) begin
        f_q[k+1] <= f_q[k];
        if (z_q[k] >= 0) begin
          x_q[k+1] <= x_q[k] - (y_q[k] >>> k);
          y_q[k+1] <= y_q[k] + (x_q[k] >>> k);
          z_q[k+1] <= z_q[k] - AtanTable[k];
        end else begin
          x_q[k+1] <= x_q[k] + (y_q[k] >>> k);
          y_q[k+1] <= y_q[k] - (x_q[k] >>> k);
          z_q[k+1] <= z_q[k] + AtanTable[k];
        end
      end
    end
  end

  // Undo the fold and clamp to plus or minus one.
  always_comb begin
    x_fin = f_q[CordicSteps] ? -x_q[CordicSteps] : x_q[CordicSteps];
    y_fin = f_q[CordicSteps] ? -y_q[CordicSteps] : y_q[CordicSteps];
    if (x_fin > Q30One) x_fin = Q30One;
    if (x_fin < -Q30One) x_fin = -Q30One;
    if (y_fin > Q30One) y_fin = Q30One;
    if (y_fin < -Q30One) y_fin = -Q30One;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cos_q <= x_fin[31:0];
      sin_q <= y_fin[31:0];
    end
  end

  // Valid bits follow the data.
  always_ff @(posedge clk) begin
    if (rst) begin
      v_q       <= '0;
      out_valid <= 1'b0;
    end else if (en) begin
      v_q       <= {v_q[CordicSteps-1:0], in_valid};
      out_valid <= v_q[CordicSteps];
    end
  end

endmodule
`default_nettype wire

// File: sv/amb_rotation.sv
`default_nettype none
module amb_rotation (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic           in_valid,
  input  amb_pkg::trig_t trig,
  input  amb_pkg::side_t side,
  output logic           out_valid,
  output amb_pkg::mat_t  mat
);
  import amb_pkg::*;

  // First products.
  logic signed [31:0] czsy, szsy, czcy, szcx, szsx, szcy, czcx, czsx, cysx, cycx;
  logic signed [31:0] a_sx, a_cx, a_sy;
  side_t              a_side;
  logic               a_valid;

  always_ff @(posedge clk) begin
    if (en) begin
      czsy   <= mul30(trig.cz, trig.sy);
      szsy   <= mul30(trig.sz, trig.sy);
      czcy   <= mul30(trig.cz, trig.cy);
      szcx   <= mul30(trig.sz, trig.cx);
      szsx   <= mul30(trig.sz, trig.sx);
      szcy   <= mul30(trig.sz, trig.cy);
      czcx   <= mul30(trig.cz, trig.cx);
      czsx   <= mul30(trig.cz, trig.sx);
      cysx   <= mul30(trig.cy, trig.sx);
      cycx   <= mul30(trig.cy, trig.cx);
      a_sx   <= trig.sx;
      a_cx   <= trig.cx;
      a_sy   <= trig.sy;
      a_side <= side;
    end
  end

  // Second products and the sums that form the rotation.
  logic signed [32:0] r00, r01, r02, r10, r11, r12, r20, r21, r22;
  side_t              b_side;
  logic               b_valid;

  always_ff @(posedge clk) begin
    if (en) begin
      r00    <= 33'(czcy);
      r01    <= 33'(mul30(czsy, a_sx)) - 33'(szcx);
      r02    <= 33'(mul30(czsy, a_cx)) + 33'(szsx);
      r10    <= 33'(szcy);
      r11    <= 33'(mul30(szsy, a_sx)) + 33'(czcx);
      r12    <= 33'(mul30(szsy, a_cx)) - 33'(czsx);
      r20    <= -33'(a_sy);
      r21    <= 33'(cysx);
      r22    <= 33'(cycx);
      b_side <= a_side;
    end
  end

  // Scale each column.
  always_ff @(posedge clk) begin
    if (en) begin
      mat.m00     <= scale30(r00, b_side.scale_x);
      mat.m01     <= scale30(r01, b_side.scale_y);
      mat.m02     <= scale30(r02, b_side.scale_z);
      mat.m10     <= scale30(r10, b_side.scale_x);
      mat.m11     <= scale30(r11, b_side.scale_y);
      mat.m12     <= scale30(r12, b_side.scale_z);
      mat.m20     <= scale30(r20, b_side.scale_x);
      mat.m21     <= scale30(r21, b_side.scale_y);
      mat.m22     <= scale30(r22, b_side.scale_z);
      mat.shift_x <= b_side.shift_x;
      mat.shift_y <= b_side.shift_y;
      mat.shift_z <= b_side.shift_z;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid   <= 1'b0;
      b_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      a_valid   <= in_valid;
      b_valid   <= a_valid;
      out_valid <= b_valid;
    end
  end

endmodule
`default_nettype wire

// File: sv/affine_model_matrix_builder_unit.sv
`default_nettype none
// Builds the 4x4 model matrix T * Rz * Ry * Rx * S from three Q4.12 angles,
// three Q16.16 scales and three Q16.16 translations, and sends it as four
// beats, top row first, the last flagged by last_row. The block is a single
// pipeline: one register for angle reduction, one per CORDIC step (16), one
// for flip and clamp, three for the rotation products and column scaling, and
// a row register that holds one matrix. The row register emits one row per
// cycle while the output is ready, so a new item is taken only when the row
// register is empty or its last row leaves; the whole pipeline holds while
// the row register is busy or the output stalls.
module affine_model_matrix_builder_unit (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  amb_pkg::in_beat_t   in_beat,
  output logic                out_valid,
  input  logic                out_ready,
  output amb_pkg::out_beat_t  out_beat
);
  import amb_pkg::*;

  logic  adv;
  logic  cx_valid, cy_valid, cz_valid;
  trig_t trig;
  side_t side_in;
  side_t side_q [CordicLat];
  logic  rot_valid;
  mat_t  mat;

  // The row register holds one matrix while its rows go out; the pipeline holds behind it.
  logic [1:0]         row_q;
  logic signed [31:0] h00, h01, h02, h10, h11, h12, h20, h21, h22, hs0, hs1, hs2;

  assign adv      = !out_valid || (out_ready && (row_q == 2'd3));
  assign in_ready = adv;

  amb_cordic u_cordic_x (
    .clk(clk), .rst(rst), .en(adv), .in_valid(in_valid && in_ready),
    .angle(in_beat.angle_x), .out_valid(cx_valid), .cos_q(trig.cx), .sin_q(trig.sx)
  );
  amb_cordic u_cordic_y (
    .clk(clk), .rst(rst), .en(adv), .in_valid(in_valid && in_ready),
    .angle(in_beat.angle_y), .out_valid(cy_valid), .cos_q(trig.cy), .sin_q(trig.sy)
  );
  amb_cordic u_cordic_z (
    .clk(clk), .rst(rst), .en(adv), .in_valid(in_valid && in_ready),
    .angle(in_beat.angle_z), .out_valid(cz_valid), .cos_q(trig.cz), .sin_q(trig.sz)
  );

  // Scale and translation wait beside the sine/cosine units.
  assign side_in = '{scale_x: in_beat.scale_x, scale_y: in_beat.scale_y,
                     scale_z: in_beat.scale_z, shift_x: in_beat.shift_x,
                     shift_y: in_beat.shift_y, shift_z: in_beat.shift_z};

  always_ff @(posedge clk) begin
    if (adv) begin
      side_q[0] <= side_in;
      for (int i = 1; i < CordicLat; i++) begin
        side_q[i] <= side_q[i-1];
      end
    end
  end

  amb_rotation u_rotation (
    .clk(clk), .rst(rst), .en(adv), .in_valid(cx_valid && cy_valid && cz_valid),
    .trig(trig), .side(side_q[CordicLat-1]), .out_valid(rot_valid), .mat(mat)
  );

  // Load a saturated matrix, then step through its rows.
  always_ff @(posedge clk) begin
    if (adv) begin
      h00 <= sat32(mat.m00);
      h01 <= sat32(mat.m01);
      h02 <= sat32(mat.m02);
      h10 <= sat32(mat.m10);
      h11 <= sat32(mat.m11);
      h12 <= sat32(mat.m12);
      h20 <= sat32(mat.m20);
      h21 <= sat32(mat.m21);
      h22 <= sat32(mat.m22);
      hs0 <= mat.shift_x;
      hs1 <= mat.shift_y;
      hs2 <= mat.shift_z;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      row_q     <= '0;
    end else if (adv) begin
      out_valid <= rot_valid;
      row_q     <= '0;
    end else if (out_ready) begin
      row_q <= row_q + 2'd1;
    end
  end

  // Row select for the output beat.
  always_comb begin
    out_beat.row_index = row_q;
    out_beat.last_row  = 1'b0;
    unique case (row_q)
      2'd0: begin
        out_beat.entry_0 = h00;
        out_beat.entry_1 = h01;
        out_beat.entry_2 = h02;
        out_beat.entry_3 = hs0;
      end
      2'd1: begin
        out_beat.entry_0 = h10;
        out_beat.entry_1 = h11;
        out_beat.entry_2 = h12;
        out_beat.entry_3 = hs1;
      end
      2'd2: begin
        out_beat.entry_0 = h20;
        out_beat.entry_1 = h21;
        out_beat.entry_2 = h22;
        out_beat.entry_3 = hs2;
      end
      default: begin
        out_beat.entry_0  = '0;
        out_beat.entry_1  = '0;
        out_beat.entry_2  = '0;
        out_beat.entry_3  = Q16One;
        out_beat.last_row = 1'b1;
      end
    endcase
  end

  // The three sine/cosine units always agree on which stages hold work.
  a_lanes_agree: assert property (@(posedge clk) disable iff (rst)
    (cx_valid == cy_valid) && (cy_valid == cz_valid))
    else $error("sine/cosine lanes out of step");

  // A taken row that is not the last is followed by the next row of the same matrix.
  a_row_step: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && (row_q != 2'd3) |=> out_valid && (row_q == $past(row_q) + 2'd1))
    else $error("row sequence broken");

  // Input is taken only when the held matrix is empty or finishing.
  a_accept_free: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |-> !out_valid || (out_ready && out_beat.last_row))
    else $error("input taken while a matrix is still pending");

  // A new matrix always starts at the top row.
  a_top_first: assert property (@(posedge clk) disable iff (rst)
    $past(adv) && out_valid |-> row_q == 2'd0)
    else $error("matrix did not start at row zero");

endmodule
`default_nettype wire

// File: verif/testbench.sv
`timescale 1ns / 100ps
`default_nettype none
module testbench;
  import amb_pkg::*;

  localparam int NumRandom = 104;
  localparam int TrigSteps = 16;
  localparam int TailCycles = 60;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_beat_t in_beat = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_beat_t out_beat;

  out_beat_t row_queue[$];
  int errors = 0;
  bit hold_sink = 1'b0;
  bit calm_phase = 1'b0;
  bit send_done = 1'b0;

  // Directed rows: a matrix row typed in where it reads off at a glance.
  typedef struct {
    in_beat_t  beat;
    bit        has_row0;
    out_beat_t row0;
  } directed_t;

  affine_model_matrix_builder_unit dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_beat(in_beat),
    .out_valid(out_valid), .out_ready(out_ready), .out_beat(out_beat)
  );

  always #10 clk = ~clk;

  initial begin
    #50ms;
    $display("testbench: done, errors");
    $finish;
  end

  // Arithmetic shift right that floors, on 64-bit signed values.
  function automatic longint shr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint round30(longint a, longint b);
    return shr(a * b + (64'sd1 <<< 29), 30);
  endfunction

  function automatic longint clip_unit(longint v);
    if (v > 64'sd1073741824) return 64'sd1073741824;
    if (v < -64'sd1073741824) return -64'sd1073741824;
    return v;
  endfunction

  // Cosine and sine in Q30 of a Q4.12 angle, by angle reduction and CORDIC.
  task automatic angle_trig(input logic signed [15:0] ang, output longint c,
                            output longint s);
    longint arc_q28[24] = '{210828714, 124459457, 65760959, 33381290, 16755422,
      8385879, 4193963, 2097109, 1048571, 524287, 262144, 131072, 65536, 32768,
      16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32};
    longint z, x, y, dx, dy;
    bit flip;
    z = longint'(ang) * 65536;
    x = 652032874;
    y = 0;
    flip = 1'b0;
    while (z > 843314857) z -= 1686629713;
    while (z <= -843314857) z += 1686629713;
    if (z > 421657428) begin
      z -= 843314857;
      flip = 1'b1;
    end else if (z < -421657428) begin
      z += 843314857;
      flip = 1'b1;
    end
    for (int i = 0; i < TrigSteps && i < 24; i++) begin
      dx = shr(y, i);
      dy = shr(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= arc_q28[i];
      end else begin
        x += dx; y -= dy; z += arc_q28[i];
      end
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    c = clip_unit(x);
    s = clip_unit(y);
  endtask

  function automatic logic signed [31:0] scaled_entry(longint r, longint sc);
    longint v;
    v = shr(r * sc + (64'sd1 <<< 29), 30);
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    if (v < -64'sd2147483648) v = -64'sd2147483648;
    return v[31:0];
  endfunction

  // Work out the four rows of the model matrix for one input beat.
  task automatic queue_matrix(input in_beat_t b);
    longint cx, sx, cy, sy, cz, sz, czsy, szsy;
    longint rot[3][3];
    longint sc[3];
    logic signed [31:0] shift[3];
    out_beat_t row;
    angle_trig(b.angle_x, cx, sx);
    angle_trig(b.angle_y, cy, sy);
    angle_trig(b.angle_z, cz, sz);
    sc = '{longint'(b.scale_x), longint'(b.scale_y), longint'(b.scale_z)};
    shift = '{b.shift_x, b.shift_y, b.shift_z};
    czsy = round30(cz, sy);
    szsy = round30(sz, sy);
    rot[0][0] = round30(cz, cy);
    rot[0][1] = round30(czsy, sx) - round30(sz, cx);
    rot[0][2] = round30(czsy, cx) + round30(sz, sx);
    rot[1][0] = round30(sz, cy);
    rot[1][1] = round30(szsy, sx) + round30(cz, cx);
    rot[1][2] = round30(szsy, cx) - round30(cz, sx);
    rot[2][0] = -sy;
    rot[2][1] = round30(cy, sx);
    rot[2][2] = round30(cy, cx);
    for (int r = 0; r < 3; r++) begin
      row.row_index = r[1:0];
      row.entry_0 = scaled_entry(rot[r][0], sc[0]);
      row.entry_1 = scaled_entry(rot[r][1], sc[1]);
      row.entry_2 = scaled_entry(rot[r][2], sc[2]);
      row.entry_3 = shift[r];
      row.last_row = 1'b0;
      row_queue.push_back(row);
    end
    row = '0;
    row.row_index = 2'd3;
    row.entry_3 = Q16One;
    row.last_row = 1'b1;
    row_queue.push_back(row);
  endtask

  function automatic in_beat_t random_beat();
    in_beat_t b;
    b.angle_x = 16'($urandom);
    b.angle_y = 16'($urandom);
    b.angle_z = 16'($urandom);
    // Mostly modest scales, sometimes full range to reach saturation.
    if ($urandom_range(3) == 0) begin
      b.scale_x = $urandom; b.scale_y = $urandom; b.scale_z = $urandom;
    end else begin
      b.scale_x = $signed(32'($urandom_range(8 << 16))) - (4 << 16);
      b.scale_y = $signed(32'($urandom_range(8 << 16))) - (4 << 16);
      b.scale_z = $signed(32'($urandom_range(8 << 16))) - (4 << 16);
    end
    b.shift_x = $urandom; b.shift_y = $urandom; b.shift_z = $urandom;
    return b;
  endfunction

  function automatic in_beat_t make_beat(int ax, int ay, int az, int sc, int sh);
    in_beat_t b;
    b.angle_x = ax[15:0]; b.angle_y = ay[15:0]; b.angle_z = az[15:0];
    b.scale_x = sc; b.scale_y = sc; b.scale_z = sc;
    b.shift_x = sh; b.shift_y = ~sh; b.shift_z = sh ^ 32'h5a5a5a5a;
    return b;
  endfunction

  // Offer one beat and wait for acceptance, idling first now and then.
  // Valid stays high after acceptance so that beats can follow back to back.
  task automatic send_beat(input in_beat_t b, input bit rand_idle);
    if (rand_idle) begin
      while ($urandom_range(99) < 25) begin
        in_valid <= 1'b0;
        @(negedge clk);
      end
    end
    in_beat <= b;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    queue_matrix(b);
    @(negedge clk);
  endtask

  // Stimulus.
  initial begin
    directed_t plan[$];
    directed_t d;
    out_beat_t zero_row;
    int one = 65536;
    int half_pi = 6434;
    int ang_list[9] = '{0, 32767, -32768, 6434, -6434, 12868, -12868, 25736, -1};
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Zero angles with unit scale: close to the identity, within CORDIC error.
    d.beat = make_beat(0, 0, 0, one, 0);
    d.has_row0 = 1'b0;
    plan.push_back(d);
    // Zero scale forces all rotation columns to zero.
    d.beat = make_beat(32767, -32768, 12345, 0, 32'h7fffffff);
    d.has_row0 = 1'b1;
    zero_row = '0;
    zero_row.entry_3 = 32'sh7fffffff;
    d.row0 = zero_row;
    plan.push_back(d);
    d.has_row0 = 1'b0;
    foreach (ang_list[i]) begin
      d.beat = make_beat(ang_list[i], ang_list[(i + 3) % 9], ang_list[(i + 5) % 9],
                         one, $urandom);
      plan.push_back(d);
    end
    // Scale extremes, which saturate.
    d.beat = make_beat(half_pi, 0, 0, 32'h7fffffff, 32'h80000000);
    plan.push_back(d);
    d.beat = make_beat(0, 0, 0, 32'h80000000, -1);
    plan.push_back(d);
    d.beat = make_beat(-half_pi, 25736, -32768, 32'h80000000, 0);
    plan.push_back(d);
    d.beat = '1;
    plan.push_back(d);
    d.beat = '0;
    plan.push_back(d);

    foreach (plan[i]) begin
      send_beat(plan[i].beat, 1'b1);
      if (plan[i].has_row0) begin
        // Replace the predicted top row with the typed-in one.
        row_queue[row_queue.size() - 4] = plan[i].row0;
      end
    end

    for (int n = 0; n < NumRandom; n++) begin
      if (n == 20) begin
        // Long output stall while inputs keep coming.
        hold_sink = 1'b1;
      end
      if (n == 40) begin
        // Sender pauses until every row has come back.
        in_valid <= 1'b0;
        @(negedge clk);
        while (row_queue.size() != 0) @(negedge clk);
      end
      calm_phase = (n >= 60 && n < 90);
      send_beat(random_beat(), !calm_phase && !hold_sink);
    end
    in_valid <= 1'b0;
    send_done = 1'b1;
  end

  // Output side: random backpressure, one long hold-off.
  initial begin
    int stall_count;
    forever begin
      @(negedge clk);
      if (hold_sink) begin
        out_ready <= 1'b0;
        for (stall_count = 0; stall_count < 200; stall_count++) @(negedge clk);
        hold_sink = 1'b0;
      end
      out_ready <= calm_phase ? 1'b1 : ($urandom_range(99) >= 25);
    end
  end

  // Compare each output beat with the oldest expected row.
  always @(posedge clk) begin
    out_beat_t want;
    if (!rst && out_valid && out_ready) begin
      if (row_queue.size() == 0) begin
        $display("%0t: unexpected row %p", $time, out_beat);
        errors++;
      end else begin
        want = row_queue.pop_front();
        if (out_beat !== want) begin
          $display("%0t: row mismatch expected %p actual %p", $time, want, out_beat);
          errors++;
        end
      end
    end
  end

  // End of run.
  initial begin
    int waited;
    wait (send_done);
    waited = 0;
    while (row_queue.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (TailCycles) @(posedge clk);
    if (row_queue.size() != 0) begin
      $display("%0t: %0d rows never arrived", $time, row_queue.size());
      errors++;
    end
    if (errors == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end
endmodule
`default_nettype wire
